// ----- hdl/chtm_pkg.sv -----
// ----------------------------------------------------------------------------
// chtm_pkg
// shared constants, types and helpers for the max convex hull trick block
// ----------------------------------------------------------------------------
`default_nettype none

package chtm_pkg;

   localparam int DEPTH   = 1024;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VAL_W   = 32;
   localparam int MUL_W   = 34;
   localparam int PROD_W  = 2 * MUL_W;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   // one stored line with the joint to the next line
   typedef struct packed {
      logic signed [VAL_W-1:0] slope;
      logic signed [VAL_W-1:0] intercept;
      logic signed [VAL_W:0]   jnum;
      logic [VAL_W-1:0]        jden;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // physical slot of logical line i counted from the front
   function automatic addr_type slot(input addr_type fp, input cnt_type i);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(fp) + (CNT_W+1)'(i);
      if (s >= (CNT_W+1)'(DEPTH)) begin
         s = s - (CNT_W+1)'(DEPTH);
      end
      return s[ADDR_W-1:0];
   endfunction

   function automatic addr_type inc_addr(input addr_type fp);
      return (fp == ADDR_W'(DEPTH - 1)) ? '0 : fp + 1'b1;
   endfunction

   function automatic addr_type dec_addr(input addr_type fp);
      return (fp == '0) ? ADDR_W'(DEPTH - 1) : fp - 1'b1;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/chtm_if.sv -----
// ----------------------------------------------------------------------------
// chtm interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface chtm_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic signed [31:0] slope;
   logic signed [31:0] intercept;
   logic signed [31:0] query_x;
   logic signed [31:0] default_result;

   modport source (output valid, operation, slope, intercept, query_x, default_result,
                   input ready);
   modport sink   (input valid, operation, slope, intercept, query_x, default_result,
                   output ready);
endinterface

interface chtm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value;
   logic               hull_empty;
   logic               overflow;

   modport source (output valid, value, hull_empty, overflow, input ready);
   modport sink   (input valid, value, hull_empty, overflow, output ready);
endinterface

`default_nettype wire

// ----- hdl/chtm_ram.sv -----
// ----------------------------------------------------------------------------
// chtm_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module chtm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- hdl/chtm_mul.sv -----
// ----------------------------------------------------------------------------
// chtm_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module chtm_mul (
   input  wire logic                                clock,
   input  wire logic signed [chtm_pkg::MUL_W-1:0]  op_a,
   input  wire logic signed [chtm_pkg::MUL_W-1:0]  op_b,
   output      logic signed [chtm_pkg::PROD_W-1:0] prod_ff
);
   import chtm_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ----- hdl/convex_hull_trick_max.sv -----
// ----------------------------------------------------------------------------
// convex_hull_trick_max
// upper envelope of lines with exact joints, binary search or trimming queries
// ----------------------------------------------------------------------------
// Lines arrive with non-increasing slopes and are pushed at the front of a
// circular line store (one ram, one read and one write a cycle). All products
// (joint cross-multiplication, x times joint denominator, slope times x) go
// through one registered multiplier, so the block takes one request at a time
// and drops ready until it is finished. An add pushes at once on an empty
// hull and ends early when an equal slope at the front settles it; otherwise
// the joint with the front line is compared with the front joint, and each
// line popped by a compare (or where the signs alone decide) brings the same
// work on the next line, amortised over adds. A query makes joint probes,
// each a ram read and a product: about ceil(log2(lines)) + 1 in search mode
// (query_order 0), one per trimmed back line plus one in trimming mode
// (query_order 1). An empty hull answers with the default result. The result
// waits in an output register, and a new request is taken while it waits.
// query_order is written through csr_we/csr_wdata; the user must do so only
// while idle; the block does not enforce it. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module convex_hull_trick_max (
   input  wire logic     clock,
   input  wire logic     reset,
   chtm_req_if.sink      req_ch,
   chtm_rsp_if.source    rsp_ch,
   input  wire logic     csr_we,
   input  wire logic     csr_wdata
);
   import chtm_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_ADD_CHK   = 10'b00_0000_0010,
      ST_JOINT     = 10'b00_0000_0100,
      ST_MUL1      = 10'b00_0000_1000,
      ST_CMP       = 10'b00_0001_0000,
      ST_PROBE_MUL = 10'b00_0010_0000,
      ST_PROBE_CMP = 10'b00_0100_0000,
      ST_EVAL_MUL  = 10'b00_1000_0000,
      ST_EVAL_ADD  = 10'b01_0000_0000,
      ST_RESULT    = 10'b10_0000_0000
   } state_type;

   // what a joint probe is deciding
   typedef enum logic [1:0] {
      PK_FIRST  = 2'd0,
      PK_SEARCH = 2'd1,
      PK_TRIM   = 2'd2
   } probe_type;

   // control state
   state_type  state_ff, state_in;
   addr_type   fp_ff, fp_in;
   cnt_type    cnt_ff, cnt_in;
   logic       ovf_ff, ovf_in;
   logic       order_ff, order_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // working registers
   logic signed [VAL_W-1:0]  a_ff, a_in, b_ff, b_in, x_ff, x_in;
   logic signed [MUL_W-1:0]  num_ff, num_in;
   logic [VAL_W-1:0]         den_ff, den_in;
   logic signed [PROD_W-1:0] p1_ff, p1_in;
   cnt_type                  lo_ff, lo_in, hi_ff, hi_in, res_ff, res_in, mid_ff, mid_in;
   probe_type                kind_ff, kind_in;
   logic signed [63:0]       val_ff, val_in;
   logic                     empty_ff, empty_in;
   logic signed [63:0]       rsp_value_ff, rsp_value_in;
   logic                     rsp_empty_ff, rsp_empty_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   // line store and shared multiplier
   logic                     wr_en, rd_en;
   addr_type                 wr_addr, rd_addr;
   entry_type                wr_data, e;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;

   chtm_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (e)
   );

   chtm_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   // joint of the new line with the front line, sign moved to the numerator
   logic signed [MUL_W-1:0] num_raw, den_raw, num_c, den_c, mag_c, mag_j;
   logic                    neg_c, neg_j;
   // push request
   logic                    do_push;
   logic signed [MUL_W-1:0] push_num;
   logic [VAL_W-1:0]        push_den;
   // joint compares
   logic                    frac_lt, above, below;
   cnt_type                 lo_n, hi_n, res_n, mid_n;
   logic [CNT_W:0]          mid_sum;
   logic                    rsp_free;

   assign num_raw = MUL_W'(b_ff) - MUL_W'(e.intercept);
   assign den_raw = MUL_W'(e.slope) - MUL_W'(a_ff);
   assign num_c   = den_raw[MUL_W-1] ? -num_raw : num_raw;
   assign den_c   = den_raw[MUL_W-1] ? -den_raw : den_raw;
   assign neg_c   = num_c[MUL_W-1];
   assign neg_j   = e.jnum[VAL_W];
   assign mag_c   = neg_c ? -num_c : num_c;
   assign mag_j   = neg_j ? -MUL_W'(e.jnum) : MUL_W'(e.jnum);

   // products are both non-negative here: p1 = |num|*jden, prod = |jnum|*den
   assign frac_lt = num_ff[MUL_W-1] ? (p1_ff > prod) : (p1_ff < prod);
   // prod = x * jden
   assign above   = prod < PROD_W'(e.jnum);
   assign below   = PROD_W'(e.jnum) < prod;

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.value     = rsp_value_ff;
   assign rsp_ch.hull_empty = rsp_empty_ff;
   assign rsp_ch.overflow  = rsp_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      fp_in        = fp_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      order_in     = csr_we ? csr_wdata : order_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      a_in         = a_ff;
      b_in         = b_ff;
      x_in         = x_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      p1_in        = p1_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      res_in       = res_ff;
      mid_in       = mid_ff;
      kind_in      = kind_ff;
      val_in       = val_ff;
      empty_in     = empty_ff;
      rsp_value_in = rsp_value_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = fp_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = fp_ff;
      mul_a        = '0;
      mul_b        = '0;
      do_push      = 1'b0;
      push_num     = '0;
      push_den     = '0;
      lo_n         = lo_ff;
      hi_n         = hi_ff;
      res_n        = res_ff;
      mid_n        = mid_ff;
      mid_sum      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               a_in = req_ch.slope;
               b_in = req_ch.intercept;
               x_in = req_ch.query_x;
               if (req_ch.operation == OP_ADD) begin
                  if (cnt_ff == '0) begin
                     // first line, no joint
                     do_push = 1'b1;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = fp_ff;
                     state_in = ST_ADD_CHK;
                  end
               end else if (cnt_ff == '0) begin
                  val_in   = 64'(req_ch.default_result);
                  empty_in = 1'b1;
                  state_in = ST_RESULT;
               end else if (order_ff) begin
                  if (cnt_ff > CNT_W'(1)) begin
                     rd_en    = 1'b1;
                     rd_addr  = slot(fp_ff, cnt_ff - CNT_W'(2));
                     kind_in  = PK_TRIM;
                     state_in = ST_PROBE_MUL;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = fp_ff;
                     state_in = ST_EVAL_MUL;
                  end
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = fp_ff;
                  if (cnt_ff == CNT_W'(1)) begin
                     state_in = ST_EVAL_MUL;
                  end else begin
                     kind_in  = PK_FIRST;
                     state_in = ST_PROBE_MUL;
                  end
               end
            end
         end

         ST_ADD_CHK: begin
            if (e.slope == a_ff) begin
               if (b_ff <= e.intercept) begin
                  state_in = ST_IDLE;
               end else if (cnt_ff == CNT_W'(1)) begin
                  // equal slope replaced and hull left empty: new line alone
                  wr_en    = 1'b1;
                  wr_addr  = fp_ff;
                  wr_data  = '{slope: a_ff, intercept: b_ff, jnum: '0, jden: '0};
                  state_in = ST_IDLE;
               end else begin
                  fp_in    = inc_addr(fp_ff);
                  cnt_in   = cnt_ff - 1'b1;
                  rd_en    = 1'b1;
                  rd_addr  = inc_addr(fp_ff);
                  state_in = ST_JOINT;
               end
            end else begin
               state_in = ST_JOINT;
            end
         end

         ST_JOINT: begin
            num_in = num_c;
            den_in = den_c[VAL_W-1:0];
            if (cnt_ff == CNT_W'(1) || (neg_c != neg_j && neg_c)) begin
               do_push  = 1'b1;
               push_num = num_c;
               push_den = den_c[VAL_W-1:0];
               state_in = ST_IDLE;
            end else if (neg_c != neg_j) begin
               fp_in    = inc_addr(fp_ff);
               cnt_in   = cnt_ff - 1'b1;
               rd_en    = 1'b1;
               rd_addr  = inc_addr(fp_ff);
            end else begin
               mul_a    = mag_c;
               mul_b    = MUL_W'(e.jden);
               state_in = ST_MUL1;
            end
         end

         ST_MUL1: begin
            p1_in    = prod;
            mul_a    = mag_j;
            mul_b    = MUL_W'(den_ff);
            state_in = ST_CMP;
         end

         ST_CMP: begin
            if (frac_lt) begin
               do_push  = 1'b1;
               push_num = num_ff;
               push_den = den_ff;
               state_in = ST_IDLE;
            end else begin
               fp_in    = inc_addr(fp_ff);
               cnt_in   = cnt_ff - 1'b1;
               rd_en    = 1'b1;
               rd_addr  = inc_addr(fp_ff);
               state_in = ST_JOINT;
            end
         end

         ST_PROBE_MUL: begin
            mul_a    = MUL_W'(x_ff);
            mul_b    = MUL_W'(e.jden);
            state_in = ST_PROBE_CMP;
         end

         ST_PROBE_CMP: begin
            rd_en    = 1'b1;
            state_in = ST_EVAL_MUL;
            case (kind_ff)
               PK_TRIM: begin
                  if (above) begin
                     // back line outdated for good
                     cnt_in = cnt_ff - 1'b1;
                     if (cnt_ff > CNT_W'(2)) begin
                        rd_addr  = slot(fp_ff, cnt_ff - CNT_W'(3));
                        state_in = ST_PROBE_MUL;
                     end else begin
                        rd_addr = fp_ff;
                     end
                  end else begin
                     rd_addr = slot(fp_ff, cnt_ff - 1'b1);
                  end
               end
               default: begin
                  if (kind_ff == PK_FIRST) begin
                     lo_n  = CNT_W'(1);
                     hi_n  = cnt_ff - 1'b1;
                     res_n = '0;
                  end else if (below) begin
                     res_n = mid_ff;
                     lo_n  = mid_ff + 1'b1;
                  end else begin
                     hi_n = mid_ff;
                  end
                  mid_sum = ((CNT_W+1)'(lo_n) + (CNT_W+1)'(hi_n)) >> 1;
                  mid_n   = mid_sum[CNT_W-1:0];
                  lo_in   = lo_n;
                  hi_in   = hi_n;
                  res_in  = res_n;
                  mid_in  = mid_n;
                  if (kind_ff == PK_FIRST && above) begin
                     rd_addr = fp_ff;
                  end else if (lo_n < hi_n) begin
                     rd_addr  = slot(fp_ff, mid_n);
                     kind_in  = PK_SEARCH;
                     state_in = ST_PROBE_MUL;
                  end else begin
                     rd_addr = slot(fp_ff, res_n + 1'b1);
                  end
               end
            endcase
         end

         ST_EVAL_MUL: begin
            mul_a    = MUL_W'(e.slope);
            mul_b    = MUL_W'(x_ff);
            state_in = ST_EVAL_ADD;
         end

         ST_EVAL_ADD: begin
            val_in   = prod[63:0] + 64'(e.intercept);
            empty_in = 1'b0;
            state_in = ST_RESULT;
         end

         ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = val_ff;
               rsp_empty_in = empty_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // push at the front, or drop on a full hull
      // the line comes straight from the request when the hull was empty
      if (do_push) begin
         if (cnt_ff >= CNT_W'(DEPTH)) begin
            ovf_in = 1'b1;
         end else begin
            wr_en   = 1'b1;
            wr_addr = dec_addr(fp_ff);
            wr_data = '{slope: a_in, intercept: b_in,
                        jnum: push_num[VAL_W:0], jden: push_den};
            fp_in   = dec_addr(fp_ff);
            cnt_in  = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fp_ff        <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         order_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fp_ff        <= fp_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      x_ff         <= x_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      p1_ff        <= p1_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      res_ff       <= res_in;
      mid_ff       <= mid_in;
      kind_ff      <= kind_in;
      val_ff       <= val_in;
      empty_ff     <= empty_in;
      rsp_value_ff <= rsp_value_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("line count above depth");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(ovf_ff))
      else $error("overflow flag cleared");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_IDLE || state_ff == ST_ADD_CHK ||
                 state_ff == ST_JOINT || state_ff == ST_CMP))
      else $error("store written outside an add");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && rsp_free) |=> rsp_valid_ff)
      else $error("finished query not presented");
`endif

endmodule

`default_nettype wire
